@@ rtl/lru_page_replacement_top_macros.svh @@
`ifndef LRU_PAGE_REPLACEMENT_TOP_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LRUPR_ASSERT_NOW(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("lrupr check failed");

// Next-cycle implication, checked outside reset.
`define LRUPR_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("lrupr check failed");

`endif

@@ rtl/lrupr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lrupr_pkg;

  localparam int CAP_W       = 5;
  localparam int OCC_W       = 5;
  localparam int FAULT_W     = 32;
  localparam int CAP_DEFAULT = 16;

  localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic step;   // request accepted this cycle
    logic hit;    // page found somewhere in the chain
    logic clear;  // capacity write: drop all entries
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/lrupr_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lrupr_cell #(
  parameter int PAGE_BITS = 16
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire lrupr_pkg::cell_ctrl_t ctrl,
  input  wire  [PAGE_BITS-1:0]   cur_page,
  input  wire                    in_cap,
  input  wire  [PAGE_BITS-1:0]   prev_page,
  input  wire                    prev_valid,
  input  wire                    above_in,
  output logic [PAGE_BITS-1:0]   page_q,
  output logic                   valid,
  output logic                   match,
  output logic                   above_out
);

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      valid <= 1'b0;
    end else if (ctrl.step && !ctrl.hit) begin
      valid <= prev_valid & in_cap;
    end
  end

  // shift from the neighbor on a miss, or on a hit at or below this cell
  always_ff @(posedge clk) begin
    if (ctrl.step && (!ctrl.hit || !above_in)) begin
      page_q <= prev_page;
    end
  end

  assign match     = valid && (page_q == cur_page);
  assign above_out = above_in | match;

endmodule

`default_nettype wire

@@ rtl/lru_page_replacement_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// The result of an accepted request is strobed on done in the next cycle.
// Accepts one request per cycle; busy is low whenever rst is low.
// The cell chain matches all frames in parallel and shifts toward the tail in that same cycle.
// Reset (rst, synchronous): table empty, fault count zero, capacity 16 (or MAX_FRAMES if less).
// A capacity write empties the table and keeps the fault count; results cannot be stalled.

module lru_page_replacement_top #(
  parameter int MAX_FRAMES = 16,
  parameter int PAGE_BITS  = 16
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             start,
  output logic                            busy,
  input  wire  [PAGE_BITS-1:0]            page,
  input  wire                             cfg_we,
  input  wire  [lrupr_pkg::CAP_W-1:0]     capacity,
  output logic                            done,
  output logic                            hit,
  output logic [lrupr_pkg::FAULT_W-1:0]   fault_count,
  output logic [lrupr_pkg::OCC_W-1:0]     occupancy
);

`include "lru_page_replacement_top_macros.svh"

  localparam int CNT_W = $clog2(MAX_FRAMES + 1);
  localparam logic [CNT_W-1:0] FRAMES = CNT_W'(MAX_FRAMES);
  localparam logic [CNT_W-1:0] CAP_RESET =
    CNT_W'((MAX_FRAMES < lrupr_pkg::CAP_DEFAULT) ? MAX_FRAMES : lrupr_pkg::CAP_DEFAULT);

  // Control registers
  logic [CNT_W-1:0]                cap_eff;     // capacity clamped to 1..MAX_FRAMES
  logic [CNT_W-1:0]                count;       // resident pages
  logic [lrupr_pkg::FAULT_W-1:0]   faults;
  logic                            hit_q;

  logic                            accept;
  logic                            hit_now;
  logic                            fault_step;  // miss with room left in the fault counter
  logic [CNT_W-1:0]                cap_next;
  lrupr_pkg::cell_ctrl_t           ctrl;

  // Chain wiring: index 0 feeds the head cell with the incoming page.
  logic [PAGE_BITS-1:0]  page_chain [MAX_FRAMES+1];
  logic [MAX_FRAMES:0]   valid_chain;
  logic [MAX_FRAMES:0]   above_chain;
  logic [MAX_FRAMES-1:0] match_vec;
  logic [MAX_FRAMES-1:0] in_cap;

  assign busy   = rst;
  assign accept = start && !busy;

  assign page_chain[0]  = page;
  assign valid_chain[0] = 1'b1;
  assign above_chain[0] = 1'b0;
  assign hit_now        = above_chain[MAX_FRAMES];
  assign fault_step     = accept && !hit_now && (faults != lrupr_pkg::FAULT_MAX);

  assign ctrl.step  = accept;
  assign ctrl.hit   = hit_now;
  assign ctrl.clear = cfg_we;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_FRAMES; gi++) begin : g_cell
      // frame lies inside the configured capacity
      assign in_cap[gi] = CNT_W'(gi) < cap_eff;

      lrupr_cell #(
        .PAGE_BITS (PAGE_BITS)
      ) u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (ctrl),
        .cur_page   (page),
        .in_cap     (in_cap[gi]),
        .prev_page  (page_chain[gi]),
        .prev_valid (valid_chain[gi]),
        .above_in   (above_chain[gi]),
        .page_q     (page_chain[gi+1]),
        .valid      (valid_chain[gi+1]),
        .match      (match_vec[gi]),
        .above_out  (above_chain[gi+1])
      );
    end
  endgenerate

  // Capacity zero behaves as one; anything above the table size saturates.
  always_comb begin
    if (capacity == '0) begin
      cap_next = CNT_W'(1);
    end else if (32'(capacity) > 32'(MAX_FRAMES)) begin
      cap_next = FRAMES;
    end else begin
      cap_next = CNT_W'(capacity);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_eff <= CAP_RESET;
    end else if (cfg_we) begin
      cap_eff <= cap_next;
    end
  end

  // Occupancy clears on reset or a capacity write and grows by one on a miss until it reaches capacity.
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      count <= '0;
    end else if (accept && !hit_now && (count != cap_eff)) begin
      count <= count + CNT_W'(1);
    end
  end

  // Saturating fault counter; survives capacity writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      faults <= '0;
    end else if (fault_step) begin
      faults <= faults + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hit_q <= hit_now;
    end
  end

  // Counters already hold the post-request values while done is high.
  assign hit         = hit_q;
  assign fault_count = faults;
  assign occupancy   = lrupr_pkg::OCC_W'(count);

  `LRUPR_ASSERT_NOW(a_count_cap, 1'b1, count <= cap_eff)
  `LRUPR_ASSERT_NOW(a_valid_prefix, 1'b1, $countones(valid_chain[MAX_FRAMES:1]) == 32'(count))
  `LRUPR_ASSERT_NOW(a_unique_match, 1'b1, $onehot0(match_vec))
  `LRUPR_ASSERT_NEXT(a_hit_keeps_count, accept && hit_now && !cfg_we, $stable(count))
  `LRUPR_ASSERT_NEXT(a_miss_faults, fault_step, faults == $past(faults) + 32'd1)

endmodule

`default_nettype wire
